>>> design/rfmr_pkg.sv
// shared types and constants for the rgba frame mismatch report block
`timescale 1ns / 1ps

package rfmr_pkg;

   // pixel and report field widths
   localparam int PIXEL_W   = 32;
   localparam int CHAN_W    = 2;
   localparam int TOTAL_W   = 25;
   localparam int POS_OUT_W = 12;
   localparam int SIZE_W    = 13;

   // configuration register indexes
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

   // entries in the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // stream widths
   localparam int REQ_DATA_W = 2 * PIXEL_W;
   localparam int RSP_DATA_W = 168;

   // per-pixel classification handed from front to back
   typedef struct packed {
      logic                frame_end;
      logic                miss;
      logic [CHAN_W-1:0]   channel;
      logic [PIXEL_W-1:0]  actual;
      logic [PIXEL_W-1:0]  expected;
   } pix_info_type;

   // frame report, first member in the highest bits
   typedef struct packed {
      logic [CHAN_W-1:0]    first_channel;
      logic [PIXEL_W-1:0]   first_actual;
      logic [PIXEL_W-1:0]   first_expected;
      logic [POS_OUT_W-1:0] box_max_row;
      logic [POS_OUT_W-1:0] box_min_row;
      logic [POS_OUT_W-1:0] box_max_col;
      logic [POS_OUT_W-1:0] box_min_col;
      logic [POS_OUT_W-1:0] first_row;
      logic [POS_OUT_W-1:0] first_col;
      logic [TOTAL_W-1:0]   mismatch_total;
   } report_type;

   localparam int REPORT_W = $bits(report_type);

   // lowest byte index at which two pixels differ
   function automatic logic [CHAN_W-1:0] first_diff_byte(
      input logic [PIXEL_W-1:0] a,
      input logic [PIXEL_W-1:0] b
   );
      logic [CHAN_W-1:0] ch;
      ch = 2'd3;
      if (a[7:0] != b[7:0]) begin
         ch = 2'd0;
      end else if (a[15:8] != b[15:8]) begin
         ch = 2'd1;
      end else if (a[23:16] != b[23:16]) begin
         ch = 2'd2;
      end
      return ch;
   endfunction

endpackage

>>> design/rfmr_fifo.sv
// small register queue between the front and back parts
`timescale 1ns / 1ps

module rfmr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  logic [WIDTH-1:0] push_data,
   output logic             push_ready,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data,
   input  logic             pop_ready
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> design/rfmr_front.sv
// front part: accepts pixel beats, tracks position and classifies each pair
`timescale 1ns / 1ps

module rfmr_front #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096,
   parameter int CW         = 12,
   parameter int RW         = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [rfmr_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [rfmr_pkg::SIZE_W-1:0]       frame_width,
   input  logic [rfmr_pkg::SIZE_W-1:0]       frame_height,
   input  logic                              push_ready,
   output logic                              push_valid,
   output logic [RW+CW+$bits(rfmr_pkg::pix_info_type)-1:0] push_data
);

   localparam int SWC  = CW + 1;
   localparam int SWR  = RW + 1;
   localparam int CMPC = (SWC > rfmr_pkg::SIZE_W) ? SWC : rfmr_pkg::SIZE_W;
   localparam int CMPR = (SWR > rfmr_pkg::SIZE_W) ? SWR : rfmr_pkg::SIZE_W;

   logic [CW-1:0]   col_ff, col_in;
   logic [RW-1:0]   row_ff, row_in;
   logic [CMPC-1:0] width_x;
   logic [CMPR-1:0] height_x;
   logic [SWC-1:0]  eff_width;
   logic [SWR-1:0]  eff_height;
   logic            row_done, frame_done, take;
   logic [rfmr_pkg::PIXEL_W-1:0] exp_px, act_px;
   rfmr_pkg::pix_info_type info;

   assign req_tready = push_ready;
   assign push_valid = req_tvalid && push_ready;
   assign take       = push_valid;
   assign exp_px     = req_tdata[rfmr_pkg::PIXEL_W-1:0];
   assign act_px     = req_tdata[rfmr_pkg::REQ_DATA_W-1:rfmr_pkg::PIXEL_W];

   // frame size clamped to one and to the maximum
   assign width_x  = CMPC'(frame_width);
   assign height_x = CMPR'(frame_height);
   always_comb begin
      if (frame_width == '0) begin
         eff_width = SWC'(1);
      end else if (width_x > CMPC'(MAX_WIDTH)) begin
         eff_width = SWC'(MAX_WIDTH);
      end else begin
         eff_width = SWC'(width_x);
      end
      if (frame_height == '0) begin
         eff_height = SWR'(1);
      end else if (height_x > CMPR'(MAX_HEIGHT)) begin
         eff_height = SWR'(MAX_HEIGHT);
      end else begin
         eff_height = SWR'(height_x);
      end
   end

   // raster position stepping
   assign row_done   = (SWC'(col_ff) + SWC'(1)) >= eff_width;
   assign frame_done = row_done && ((SWR'(row_ff) + SWR'(1)) >= eff_height);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (take) begin
         if (row_done) begin
            col_in = '0;
            row_in = frame_done ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // classification of the pixel pair
   always_comb begin
      info.frame_end = frame_done;
      info.miss      = (exp_px != act_px);
      info.channel   = rfmr_pkg::first_diff_byte(exp_px, act_px);
      info.actual    = act_px;
      info.expected  = exp_px;
   end

   assign push_data = {row_ff, col_ff, info};

endmodule

>>> design/rfmr_back.sv
// back part: accumulates mismatch statistics and holds the frame report
`timescale 1ns / 1ps

module rfmr_back #(
   parameter int CW = 12,
   parameter int RW = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                pop_valid,
   input  logic [RW+CW+$bits(rfmr_pkg::pix_info_type)-1:0] pop_data,
   output logic                                pop_ready,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rfmr_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   localparam int IW = $bits(rfmr_pkg::pix_info_type);
   localparam int XC = (CW > rfmr_pkg::POS_OUT_W) ? CW : rfmr_pkg::POS_OUT_W;
   localparam int XR = (RW > rfmr_pkg::POS_OUT_W) ? RW : rfmr_pkg::POS_OUT_W;
   localparam logic [rfmr_pkg::TOTAL_W-1:0] TOTAL_MAX = '1;

   rfmr_pkg::pix_info_type info;
   logic [CW-1:0] col;
   logic [RW-1:0] row;

   logic [rfmr_pkg::TOTAL_W-1:0] count_ff, count_in;
   logic [CW-1:0]                first_col_ff, first_col_in;
   logic [RW-1:0]                first_row_ff, first_row_in;
   logic [CW-1:0]                min_col_ff, min_col_in, max_col_ff, max_col_in;
   logic [RW-1:0]                min_row_ff, min_row_in, max_row_ff, max_row_in;
   logic [rfmr_pkg::PIXEL_W-1:0] first_exp_ff, first_exp_in;
   logic [rfmr_pkg::PIXEL_W-1:0] first_act_ff, first_act_in;
   logic [rfmr_pkg::CHAN_W-1:0]  first_ch_ff, first_ch_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   rfmr_pkg::report_type         report_ff, report_in;
   logic                         pop, load;

   assign info = rfmr_pkg::pix_info_type'(pop_data[IW-1:0]);
   assign col  = pop_data[IW+CW-1:IW];
   assign row  = pop_data[IW+CW+RW-1:IW+CW];

   // a frame end beat waits until the report register is free
   assign pop_ready = !info.frame_end || !rsp_valid_ff || rsp_tready;
   assign pop       = pop_valid && pop_ready;
   assign load      = pop && info.frame_end;

   // accumulator update for one beat
   always_comb begin
      count_in     = count_ff;
      first_col_in = first_col_ff;
      first_row_in = first_row_ff;
      min_col_in   = min_col_ff;
      max_col_in   = max_col_ff;
      min_row_in   = min_row_ff;
      max_row_in   = max_row_ff;
      first_exp_in = first_exp_ff;
      first_act_in = first_act_ff;
      first_ch_in  = first_ch_ff;
      if (pop && info.miss) begin
         if (count_ff == '0) begin
            first_col_in = col;
            first_row_in = row;
            min_col_in   = col;
            max_col_in   = col;
            min_row_in   = row;
            max_row_in   = row;
            first_exp_in = info.expected;
            first_act_in = info.actual;
            first_ch_in  = info.channel;
         end else begin
            if (col < min_col_ff) min_col_in = col;
            if (col > max_col_ff) max_col_in = col;
            if (row < min_row_ff) min_row_in = row;
            if (row > max_row_ff) max_row_in = row;
         end
         if (count_ff != TOTAL_MAX) begin
            count_in = count_ff + rfmr_pkg::TOTAL_W'(1);
         end
      end
   end

   // report built from the updated accumulators, positions kept to the low bits
   always_comb begin
      report_in.mismatch_total = count_in;
      report_in.first_col      = rfmr_pkg::POS_OUT_W'(XC'(first_col_in));
      report_in.first_row      = rfmr_pkg::POS_OUT_W'(XR'(first_row_in));
      report_in.box_min_col    = rfmr_pkg::POS_OUT_W'(XC'(min_col_in));
      report_in.box_max_col    = rfmr_pkg::POS_OUT_W'(XC'(max_col_in));
      report_in.box_min_row    = rfmr_pkg::POS_OUT_W'(XR'(min_row_in));
      report_in.box_max_row    = rfmr_pkg::POS_OUT_W'(XR'(max_row_in));
      report_in.first_expected = first_exp_in;
      report_in.first_actual   = first_act_in;
      report_in.first_channel  = first_ch_in;
   end

   // accumulators clear after each report
   always_ff @(posedge clock) begin
      if (reset || load) begin
         count_ff     <= '0;
         first_col_ff <= '0;
         first_row_ff <= '0;
         min_col_ff   <= '0;
         max_col_ff   <= '0;
         min_row_ff   <= '0;
         max_row_ff   <= '0;
         first_exp_ff <= '0;
         first_act_ff <= '0;
         first_ch_ff  <= '0;
      end else begin
         count_ff     <= count_in;
         first_col_ff <= first_col_in;
         first_row_ff <= first_row_in;
         min_col_ff   <= min_col_in;
         max_col_ff   <= max_col_in;
         min_row_ff   <= min_row_in;
         max_row_ff   <= max_row_in;
         first_exp_ff <= first_exp_in;
         first_act_ff <= first_act_in;
         first_ch_ff  <= first_ch_in;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         report_ff <= report_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rfmr_pkg::RSP_DATA_W'(report_ff);

`ifndef SYNTHESIS
   // accumulators are empty right after a report is taken in
   a_clear_after_load: assert property (@(posedge clock) disable iff (reset)
      load |=> (count_ff == '0) && (first_exp_ff == '0) && (first_act_ff == '0))
      else $error("accumulators not cleared after frame report");

   // no mismatch yet means no recorded position
   a_empty_means_zero: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (min_col_ff == '0) && (max_row_ff == '0) &&
                           (first_col_ff == '0) && (first_ch_ff == '0))
      else $error("position state set without any mismatch");

   // bounding box stays ordered
   a_box_ordered: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> (min_col_ff <= max_col_ff) && (min_row_ff <= max_row_ff))
      else $error("bounding box inverted");

   // a pending report is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !load)
      else $error("report overwritten before it was taken");
`endif

endmodule

>>> design/rgba_frame_mismatch_report_core.sv
// top level of the rgba frame mismatch report block
`timescale 1ns / 1ps

// Compares an expected and an actual RGBA8 frame, one pixel pair per beat in
// raster order, and emits one report beat after the last pixel of each frame.
// One pixel beat is taken per clock cycle while the queue is not full; the
// front stage steps the raster position and classifies the pair, a four-entry
// queue decouples it from the back stage that accumulates count, first
// mismatch and bounding box. The last pixel passes through the queue and the
// report is then registered in an output register; while it waits, pixels
// keep flowing until the last pixel of the next frame reaches the head of the
// queue. Frame size registers must be written only while no beat is in
// flight; the block itself does not enforce this. Zero counts as one and
// values above MAX_WIDTH or MAX_HEIGHT saturate there.

module rgba_frame_mismatch_report_core #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // pixel pair beats
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // expected_pixel[31:0], actual_pixel[63:32]
   input  logic [rfmr_pkg::REQ_DATA_W-1:0]      req_tdata,
   // frame report beats
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // mismatch_total[24:0], first_col[36:25], first_row[48:37],
   // box_min_col[60:49], box_max_col[72:61], box_min_row[84:73],
   // box_max_row[96:85], first_expected[128:97], first_actual[160:129],
   // first_channel[162:161], zero[167:163]
   output logic [rfmr_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // register write port
   input  logic                                 csr_we,
   input  logic [rfmr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [rfmr_pkg::SIZE_W-1:0]          csr_wdata
);

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int QW = RW + CW + $bits(rfmr_pkg::pix_info_type);

   logic [rfmr_pkg::SIZE_W-1:0] width_ff, width_in;
   logic [rfmr_pkg::SIZE_W-1:0] height_ff, height_in;
   logic                        push_valid, push_ready, pop_valid, pop_ready;
   logic [QW-1:0]               push_data, pop_data;

   // frame size registers
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         unique case (csr_index)
            rfmr_pkg::REG_FRAME_WIDTH:  width_in  = csr_wdata;
            rfmr_pkg::REG_FRAME_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= rfmr_pkg::SIZE_W'(1);
         height_ff <= rfmr_pkg::SIZE_W'(1);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   rfmr_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .CW         (CW),
      .RW         (RW)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .frame_width  (width_ff),
      .frame_height (height_ff),
      .push_ready   (push_ready),
      .push_valid   (push_valid),
      .push_data    (push_data)
   );

   rfmr_fifo #(
      .WIDTH (QW),
      .DEPTH (rfmr_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready)
   );

   rfmr_back #(
      .CW (CW),
      .RW (RW)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
